// ----- sv/ppid_pkg.sv -----
// Shared widths, payload types and register indexes for the positional PID controller.
`timescale 1ns / 1ps

package ppid_pkg;

  localparam int IN_W   = 16;             // setpoint and measurement width
  localparam int GAIN_W = 16;             // Q8.8 gain width
  localparam int ERR_W  = IN_W + 1;       // error of two 16-bit values
  localparam int SUM_W  = ERR_W + 1;      // clamped integral plus one error
  localparam int DER_W  = ERR_W + 1;      // difference of two errors
  localparam int PP_W   = GAIN_W + ERR_W; // proportional product
  localparam int PI_W   = GAIN_W + SUM_W; // integral product
  localparam int PD_W   = GAIN_W + DER_W; // derivative product
  localparam int ACC_W  = PI_W + 2;       // sum of three products
  localparam int FRAC_W = 8;              // Q8.8 fraction bits
  localparam int OUT_W  = 32;             // drive value width
  localparam int IDX_W  = 2;              // configuration index width

  localparam logic [GAIN_W-1:0] RESET_LIMIT = GAIN_W'(4000);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_D = 2'd2;
  localparam logic [IDX_W-1:0] REG_LIMIT  = 2'd3;

  typedef logic signed [IN_W-1:0]   in_t;
  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [DER_W-1:0]  der_t;
  typedef logic signed [PP_W-1:0]   prod_p_t;
  typedef logic signed [PI_W-1:0]   prod_i_t;
  typedef logic signed [PD_W-1:0]   prod_d_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [OUT_W-1:0]  drive_t;

  // Gains as seen by the multiplier stage
  typedef struct packed {
    gain_t gain_p;
    gain_t gain_i;
    gain_t gain_d;
  } gains_t;

  // Error stage result
  typedef struct packed {
    err_t err;
    sum_t sum;
    der_t derr;
  } err_stage_t;

  // Multiplier stage result
  typedef struct packed {
    prod_p_t prod_p;
    prod_i_t prod_i;
    prod_d_t prod_d;
  } prod_stage_t;

endpackage

// ----- sv/ppid_err.sv -----
// Error stage: forms the error, clamps and updates the integral, shifts the error history.
`timescale 1ns / 1ps

module ppid_err (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ppid_pkg::in_t                 target_value,
  input  ppid_pkg::in_t                 measured_value,
  input  logic [ppid_pkg::GAIN_W-1:0]   integral_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ppid_pkg::err_stage_t          out_data
);

  logic                  valid_r;
  ppid_pkg::err_stage_t  data_r;
  ppid_pkg::sum_t        error_sum_r;
  ppid_pkg::err_t        last_err_r;
  ppid_pkg::err_t        prior_err_r;

  logic                  advance;
  ppid_pkg::err_t        err;
  ppid_pkg::sum_t        lim_pos;
  ppid_pkg::sum_t        lim_neg;
  ppid_pkg::sum_t        sum_clamped;
  ppid_pkg::sum_t        sum_nxt;
  ppid_pkg::der_t        derr;

  assign in_ready = !valid_r || out_ready;
  assign advance  = in_valid && in_ready;

  // Error of sign-extended operands
  assign err = $signed({target_value[ppid_pkg::IN_W-1], target_value})
             - $signed({measured_value[ppid_pkg::IN_W-1], measured_value});

  // Clamp the kept sum before adding the new error
  assign lim_pos = $signed({2'b00, integral_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (error_sum_r > lim_pos) begin
      sum_clamped = lim_pos;
    end else if (error_sum_r < lim_neg) begin
      sum_clamped = lim_neg;
    end else begin
      sum_clamped = error_sum_r;
    end
  end

  assign sum_nxt = sum_clamped + $signed({err[ppid_pkg::ERR_W-1], err});

  // Derivative from the two previous errors
  assign derr = $signed({last_err_r[ppid_pkg::ERR_W-1], last_err_r})
              - $signed({prior_err_r[ppid_pkg::ERR_W-1], prior_err_r});

  // Controller state and stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      error_sum_r <= '0;
      last_err_r  <= '0;
      prior_err_r <= '0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (advance) begin
        error_sum_r <= sum_nxt;
        last_err_r  <= err;
        prior_err_r <= last_err_r;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (advance) begin
      data_r.err  <= err;
      data_r.sum  <= sum_nxt;
      data_r.derr <= derr;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- sv/ppid_mul.sv -----
// Multiplier stage: the three gain products, each registered.
`timescale 1ns / 1ps

module ppid_mul (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ppid_pkg::err_stage_t   in_data,
  input  ppid_pkg::gains_t       gains,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ppid_pkg::prod_stage_t  out_data
);

  logic                   valid_r;
  ppid_pkg::prod_stage_t  data_r;
  logic                   advance;
  ppid_pkg::prod_p_t      prod_p;
  ppid_pkg::prod_i_t      prod_i;
  ppid_pkg::prod_d_t      prod_d;

  assign in_ready = !valid_r || out_ready;
  assign advance  = in_valid && in_ready;

  // Signed products at their full widths
  assign prod_p = in_data.err  * gains.gain_p;
  assign prod_i = in_data.sum  * gains.gain_i;
  assign prod_d = in_data.derr * gains.gain_d;

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (advance) begin
      data_r.prod_p <= prod_p;
      data_r.prod_i <= prod_i;
      data_r.prod_d <= prod_d;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- sv/ppid_out.sv -----
// Output stage: adds the products, drops the fraction bits, holds the result.
`timescale 1ns / 1ps

module ppid_out (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ppid_pkg::prod_stage_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ppid_pkg::drive_t       out_data
);

  localparam int KEEP_W = ppid_pkg::ACC_W - ppid_pkg::FRAC_W;

  logic              valid_r;
  ppid_pkg::drive_t  drive_r;
  logic              advance;
  ppid_pkg::acc_t    acc;
  ppid_pkg::drive_t  drive_nxt;

  assign in_ready = !valid_r || out_ready;
  assign advance  = in_valid && in_ready;

  // Sum of sign-extended products
  assign acc = ppid_pkg::acc_t'(in_data.prod_p)
             + ppid_pkg::acc_t'(in_data.prod_i)
             + ppid_pkg::acc_t'(in_data.prod_d);

  // Floor shift: drop the Q8.8 fraction, sign-extend to the output
  assign drive_nxt = {{(ppid_pkg::OUT_W - KEEP_W){acc[ppid_pkg::ACC_W-1]}},
                      acc[ppid_pkg::ACC_W-1:ppid_pkg::FRAC_W]};

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = drive_r;

endmodule

// ----- sv/positional_pid_with_integral_clamp.sv -----
// Top level of the positional PID controller with integral clamp.
//
//   channel  direction  tdata (low bit up)                       tuser/tlast
//   in_      slave      target_value[15:0], measured_value[31:16] none
//   out_     master     drive_value[31:0]                         none
//   cfg_     write      index 0 gain_p, 1 gain_i, 2 gain_d, 3 integral_limit
//
// One item is taken every cycle unless the pipeline stalls. The input
// register loads at the transfer edge, then the error, multiplier and
// output stages each register the item in turn. The rate is set by the
// error stage, where the clamp and add of the integral close a loop
// through the integral register. Each stage stalls only when the stage
// after it is full and not draining, so items are still accepted while a
// result waits, until the stages fill.
// Synchronous reset clears the pipeline, the integral and error history, sets
// the gains to zero and the integral limit to 4000.
`timescale 1ns / 1ps

module positional_pid_with_integral_clamp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // target_value[15:0], measured_value[31:16]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // drive_value[31:0]
  input  logic                          cfg_we,
  input  logic [ppid_pkg::IDX_W-1:0]    cfg_addr,
  input  logic [ppid_pkg::GAIN_W-1:0]   cfg_wdata
);

  ppid_pkg::gains_t             gains_r;
  logic [ppid_pkg::GAIN_W-1:0]  limit_r;

  logic                         in_valid_r;
  ppid_pkg::in_t                target_r;
  ppid_pkg::in_t                measured_r;
  logic                         in_advance;

  logic                         err_ready;
  logic                         err_valid;
  ppid_pkg::err_stage_t         err_data;
  logic                         mul_ready;
  logic                         mul_valid;
  ppid_pkg::prod_stage_t        mul_data;
  logic                         out_ready_int;
  ppid_pkg::drive_t             drive;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
      limit_r <= ppid_pkg::RESET_LIMIT;
    end else if (cfg_we) begin
      case (cfg_addr)
        ppid_pkg::REG_GAIN_P: gains_r.gain_p <= $signed(cfg_wdata);
        ppid_pkg::REG_GAIN_I: gains_r.gain_i <= $signed(cfg_wdata);
        ppid_pkg::REG_GAIN_D: gains_r.gain_d <= $signed(cfg_wdata);
        ppid_pkg::REG_LIMIT:  limit_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  assign in_tready  = !in_valid_r || err_ready;
  assign in_advance = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance) begin
      target_r   <= $signed(in_tdata[ppid_pkg::IN_W-1:0]);
      measured_r <= $signed(in_tdata[2*ppid_pkg::IN_W-1:ppid_pkg::IN_W]);
    end
  end

  ppid_err u_err (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid_r),
    .in_ready       (err_ready),
    .target_value   (target_r),
    .measured_value (measured_r),
    .integral_limit (limit_r),
    .out_valid      (err_valid),
    .out_ready      (mul_ready),
    .out_data       (err_data)
  );

  ppid_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (err_valid),
    .in_ready  (mul_ready),
    .in_data   (err_data),
    .gains     (gains_r),
    .out_valid (mul_valid),
    .out_ready (out_ready_int),
    .out_data  (mul_data)
  );

  ppid_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (out_ready_int),
    .in_data   (mul_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (drive)
  );

  assign out_tdata = drive;

endmodule

// ----- sv/ppid_chk.sv -----
// Port-level checks for the positional PID controller, bound to the top level.
`timescale 1ns / 1ps

module ppid_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [31:0]  out_tdata
);

  // Pipeline is empty and open right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("pipeline not empty after reset");

  // With the sink always ready, a transfer yields a result at the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && out_tready) ##1 out_tready ##1 out_tready ##1 out_tready
      |=> out_tvalid)
    else $error("result missing four cycles after transfer");

  // Held result keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped while stalled");

  // Held result keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind positional_pid_with_integral_clamp ppid_chk u_ppid_chk (.*);
